// ===== hdl/lfla_pkg.sv =====
// Package for the free-list node allocator: field widths, operation and
// status codes, and the item and link-write structs used by the modules.
// No dependencies.
`timescale 1ns / 1ps

package lfla_pkg;

   // Field widths of the request and response items
   localparam int NODE_W   = 11;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_BITS  = MODE_W + NODE_W;
   localparam int RSP_BITS  = NODE_W + STATUS_W + NODE_W + NODE_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   // Pool size defaults
   localparam int DEF_MAX_NODES = 1024;
   localparam logic [NODE_W-1:0] CAPACITY_RESET = NODE_W'(1024);

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_in;
      mode_type          mode;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] peak_in_use;
      logic [NODE_W-1:0] in_use;
      status_type        status;
      logic [NODE_W-1:0] node_out;
   } rsp_type;

   // One write into the link store
   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] addr;
      logic [NODE_W-1:0] data;
   } link_wr_type;

endpackage

// ===== hdl/lfla_link_ram.sv =====
// Link store of the allocator: one write port, one registered read port.
// Depends on lfla_pkg.
`timescale 1ns / 1ps

module lfla_link_ram #(
   parameter int DEPTH = lfla_pkg::DEF_MAX_NODES + 2
) (
   input  logic                         clock,
   input  lfla_pkg::link_wr_type        wr,
   input  logic [lfla_pkg::NODE_W-1:0]  rd_addr,
   output logic [lfla_pkg::NODE_W-1:0]  rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [lfla_pkg::NODE_W-1:0] link_mem [DEPTH];
   logic [lfla_pkg::NODE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         link_mem[ADDR_W'(wr.addr)] <= wr.data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= link_mem[ADDR_W'(rd_addr)];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lfla_exec.sv =====
// Allocator state (free head, in-use count, peak) and the single-pass
// logic that turns one request plus the head's link into one response.
// Depends on lfla_pkg.
`timescale 1ns / 1ps

module lfla_exec #(
   parameter int MAX_NODES = lfla_pkg::DEF_MAX_NODES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         commit,
   input  lfla_pkg::req_type            req,
   input  logic [lfla_pkg::NODE_W-1:0]  head_link_raw,
   input  logic [lfla_pkg::NODE_W-1:0]  capacity,
   output logic [lfla_pkg::NODE_W-1:0]  head_addr,
   output lfla_pkg::link_wr_type        link_wr,
   output lfla_pkg::rsp_type            rsp
);

   localparam int NW = lfla_pkg::NODE_W;

   logic [NW-1:0] head_ff, head_in;
   logic [NW-1:0] used_ff, used_in;
   logic [NW-1:0] peak_ff, peak_in;
   logic          link1_zero_ff, link1_zero_in;

   logic [NW-1:0] cap_eff;
   logic [NW-1:0] head_link;
   logic [NW-1:0] next_head;

   // effective capacity = min(register, pool size)
   assign cap_eff = (32'(capacity) < MAX_NODES) ? capacity : NW'(MAX_NODES);

   // node 1's link is zero after reset or clear until a free writes it
   assign head_link = (head_ff == NW'(1) && link1_zero_ff) ? '0 : head_link_raw;

   assign head_addr = head_ff;

   always_comb begin
      head_in       = head_ff;
      used_in       = used_ff;
      peak_in       = peak_ff;
      link1_zero_in = link1_zero_ff;
      link_wr       = '0;
      next_head     = head_link;
      rsp.node_out  = '0;
      rsp.status    = lfla_pkg::ST_OK;

      case (req.mode)
         lfla_pkg::MODE_ALLOC: begin
            if (used_ff >= cap_eff) begin
               rsp.status = lfla_pkg::ST_EXHAUSTED;
            end else begin
               // zero link: everything above is untouched, step to head+1
               if (head_link == '0) begin
                  next_head    = head_ff + NW'(1);
                  link_wr.we   = 1'b1;
                  link_wr.addr = next_head;
                  link_wr.data = '0;
               end
               head_in      = next_head;
               used_in      = used_ff + NW'(1);
               if (used_in > peak_ff) begin
                  peak_in = used_in;
               end
               rsp.node_out = head_ff;
            end
         end
         lfla_pkg::MODE_FREE: begin
            if (used_ff == '0) begin
               rsp.status = lfla_pkg::ST_EMPTY;
            end else if (req.node_in == '0 || req.node_in > cap_eff) begin
               rsp.status = lfla_pkg::ST_BAD_INDEX;
            end else begin
               // push onto the head
               link_wr.we   = 1'b1;
               link_wr.addr = req.node_in;
               link_wr.data = head_ff;
               head_in      = req.node_in;
               used_in      = used_ff - NW'(1);
               if (req.node_in == NW'(1)) begin
                  link1_zero_in = 1'b0;
               end
            end
         end
         lfla_pkg::MODE_CLEAR: begin
            head_in       = NW'(1);
            used_in       = '0;
            peak_in       = '0;
            link1_zero_in = 1'b1;
         end
         default: begin
         end
      endcase

      if (!commit) begin
         link_wr.we = 1'b0;
      end

      rsp.in_use      = used_in;
      rsp.peak_in_use = peak_in;
   end

   // state update once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= NW'(1);
         used_ff       <= '0;
         peak_ff       <= '0;
         link1_zero_ff <= 1'b1;
      end else if (commit) begin
         head_ff       <= head_in;
         used_ff       <= used_in;
         peak_ff       <= peak_in;
         link1_zero_ff <= link1_zero_in;
      end
   end

endmodule

// ===== hdl/lazy_free_list_allocator.sv =====
// Top level of the free-list node allocator: stream handshakes, request
// and response registers, capacity register. Uses lfla_pkg, lfla_link_ram
// and lfla_exec.
//
//  channel   direction  handshake                  payload
//  req_      in         req_tvalid / req_tready    req_tdata  (mode, node_in)
//  rsp_      out        rsp_tvalid / rsp_tready    rsp_tdata  (node_out, status,
//                                                   in_use, peak_in_use)
//  csr_      in         csr_we                     csr_wdata  (pool_capacity)
//
// Each item is handled in order: the accept edge latches the request and reads the
// head's link from the synchronous link store; the commit edge applies the
// update and loads the response register. No new item is taken until commit.
// A response waiting on rsp_tready holds the item in its update cycle; the
// next request is still accepted while the response register is full.
// Synchronous reset: head 1, counts 0, capacity 1024; link store is not cleared.
`timescale 1ns / 1ps

module lazy_free_list_allocator #(
   parameter int MAX_NODES = lfla_pkg::DEF_MAX_NODES
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: [1:0] mode, [12:2] node_in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lfla_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // response: [10:0] node_out, [12:11] status, [23:13] in_use, [34:24] peak_in_use
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lfla_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // capacity register write
   input  logic                               csr_we,
   input  logic [lfla_pkg::NODE_W-1:0]        csr_wdata
);

   localparam int DEPTH = MAX_NODES + 2;

   logic                        busy_ff, busy_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lfla_pkg::req_type           req_ff;
   lfla_pkg::rsp_type           rsp_ff;
   logic [lfla_pkg::NODE_W-1:0] capacity_ff;

   lfla_pkg::req_type           req_unpacked;
   lfla_pkg::rsp_type           rsp_next;
   lfla_pkg::link_wr_type       link_wr;
   logic [lfla_pkg::NODE_W-1:0] head_addr;
   logic [lfla_pkg::NODE_W-1:0] head_link;
   logic                        accept;
   logic                        commit;

   // handshake
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign commit     = busy_ff && (!rsp_valid_ff || rsp_tready);

   assign busy_in      = accept ? 1'b1 : (commit ? 1'b0 : busy_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign req_unpacked = lfla_pkg::req_type'(req_tdata[lfla_pkg::REQ_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= lfla_pkg::CAPACITY_RESET;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_unpacked;
      end
      if (commit) begin
         rsp_ff <= rsp_next;
      end
   end

   lfla_link_ram #(
      .DEPTH (DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (head_addr),
      .rd_data (head_link)
   );

   lfla_exec #(
      .MAX_NODES (MAX_NODES)
   ) u_exec (
      .clock         (clock),
      .reset         (reset),
      .commit        (commit),
      .req           (req_ff),
      .head_link_raw (head_link),
      .capacity      (capacity_ff),
      .head_addr     (head_addr),
      .link_wr       (link_wr),
      .rsp           (rsp_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lfla_pkg::RSP_TDATA_W'(rsp_ff);

endmodule
